// ----- hw/rtl/ilir_pkg.sv -----
// Shared types and constants for the indexed list insert/remove block.
`default_nettype none

package ilir_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int OPC_W     = 2;
	localparam int POS_W     = 7;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 7;
	localparam int TDATA_W   = 48;

	typedef enum logic [OPC_W-1:0] {
		OP_GET    = 2'd0,
		OP_SET    = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic    upd;
		opcode_t op;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/indexed_list_insert_remove.sv -----
// Top level of the indexed list: bounds check, entry count and the row of entry cells.
//
// channel  | dir | tdata fields (low bit up)                    | width
// s_axis   | in  | opcode[1:0] position[8:2] data_in[40:9]      | 48
// m_axis   | out | data_out[31:0] status[33:32] count[40:34]    | 48
//
// One transaction per cycle: every cell compares its own index with the
// position and takes its new word from the input, its left or its right
// neighbor in the same clock edge. The result sits in an output register;
// a new transaction is taken whenever that register is empty or being drained.
// Reset clears the entry count and the output valid; entry words need no reset.
`default_nettype none

module indexed_list_insert_remove #(
	parameter int DEPTH = ilir_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// opcode[1:0], position[8:2], data_in[40:9], zero pad
	input  wire logic [ilir_pkg::TDATA_W-1:0] s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// data_out[31:0], status[33:32], count[40:34], zero pad
	output logic      [ilir_pkg::TDATA_W-1:0] m_axis_tdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
	localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

	logic                          s_acc;
	ilir_pkg::opcode_t             op;
	logic [ilir_pkg::POS_W-1:0]    pos;
	logic [ilir_pkg::DATA_W-1:0]   din;
	logic [CMPW-1:0]               pos_x;
	logic [CMPW-1:0]               cnt_x;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	ilir_pkg::status_t             status;
	logic                          ok;
	ilir_pkg::cell_ctl_t           ctl;
	logic [ilir_pkg::DATA_W-1:0]   word [DEPTH];
	logic [ilir_pkg::DATA_W-1:0]   rd   [DEPTH];
	logic [ilir_pkg::DATA_W-1:0]   rd_or;
	logic [ilir_pkg::DATA_W-1:0]   rd_val;
	logic                          out_vld_q;
	logic [ilir_pkg::DATA_W-1:0]   out_data_q;
	ilir_pkg::status_t             out_stat_q;
	logic [ilir_pkg::CNT_W-1:0]    out_cnt_q;

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign op    = ilir_pkg::opcode_t'(s_axis_tdata[1:0]);
	assign pos   = s_axis_tdata[8:2];
	assign din   = s_axis_tdata[40:9];
	assign pos_x = CMPW'(pos);
	assign cnt_x = CMPW'(count_q);

	always_comb begin
		status = ilir_pkg::ST_OK;
		if (op == ilir_pkg::OP_INSERT) begin
			if (pos_x > cnt_x) status = ilir_pkg::ST_BOUNDS;
			else if (cnt_x == DEPTH_X) status = ilir_pkg::ST_FULL;
		end else if (pos_x >= cnt_x) begin
			status = ilir_pkg::ST_BOUNDS;
		end
	end

	assign ok = (status == ilir_pkg::ST_OK);

	always_comb begin
		count_d = count_q;
		if (ok && op == ilir_pkg::OP_INSERT) count_d = count_q + CW'(1);
		else if (ok && op == ilir_pkg::OP_REMOVE) count_d = count_q - CW'(1);
	end

	assign ctl.upd = s_acc && ok;
	assign ctl.op  = op;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ilir_pkg::DATA_W-1:0] left;
		logic [ilir_pkg::DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = word[i+1];
		end

		ilir_cell #(
			.CMPW  (CMPW),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (pos_x),
			.din   (din),
			.left  (left),
			.right (right),
			.word  (word[i]),
			.rd    (rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd[i];
		end
	end

	assign rd_val = (ok && op == ilir_pkg::OP_GET) ? rd_or : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_acc) begin
				count_q   <= count_d;
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			out_data_q <= rd_val;
			out_stat_q <= status;
			out_cnt_q  <= ilir_pkg::CNT_W'(count_d);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, out_cnt_q, out_stat_q, out_data_q};

endmodule

`default_nettype wire

// ----- hw/rtl/ilir_cell.sv -----
// One list entry cell: holds a word and shifts with its neighbors on insert and remove.
`default_nettype none

module ilir_cell #(
	parameter int CMPW  = 7,
	parameter int INDEX = 0
) (
	input  wire logic                      clk,
	input  wire ilir_pkg::cell_ctl_t       ctl,
	input  wire logic [CMPW-1:0]           pos,
	input  wire logic [ilir_pkg::DATA_W-1:0] din,
	input  wire logic [ilir_pkg::DATA_W-1:0] left,
	input  wire logic [ilir_pkg::DATA_W-1:0] right,
	output logic      [ilir_pkg::DATA_W-1:0] word,
	output logic      [ilir_pkg::DATA_W-1:0] rd
);

	localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

	logic [ilir_pkg::DATA_W-1:0] word_q;
	logic                        hit;
	logic                        above;

	assign hit   = (pos == IDX);
	assign above = (IDX > pos);

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			case (ctl.op)
				ilir_pkg::OP_SET: begin
					if (hit) word_q <= din;
				end
				ilir_pkg::OP_INSERT: begin
					if (hit) word_q <= din;
					else if (above) word_q <= left;
				end
				ilir_pkg::OP_REMOVE: begin
					if (hit || above) word_q <= right;
				end
				default: begin
				end
			endcase
		end
	end

	assign word = word_q;
	assign rd   = hit ? word_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/ilir_chk.sv -----
// Port-level checks for the indexed list, bound to the top level.
`default_nettype none

module ilir_chk #(
	parameter int DEPTH = ilir_pkg::DEPTH_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_axis_tvalid,
	input wire logic                         s_axis_tready,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [ilir_pkg::TDATA_W-1:0] m_axis_tdata
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[33:32] != ilir_pkg::ST_OK) |->
		(m_axis_tdata[31:0] == '0))
		else $error("error result carries nonzero data");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output register");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
		else $error("accepted transaction gave no result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (int'(m_axis_tdata[40:34]) <= DEPTH))
		else $error("count exceeds depth");

endmodule

bind indexed_list_insert_remove ilir_chk #(
	.DEPTH (DEPTH)
) u_ilir_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
